// ===== hw/rtl/p2tr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2tr_pkg
// shared widths, register indexes, command codes and the control/status
// structs between the controller and the datapath
// ----------------------------------------------------------------------------
package p2tr_pkg;

  localparam int MAX_SIDE_DEF = 256;   // default largest source side

  localparam int COL_W   = 8;          // width of the col and row fields
  localparam int PIX_W   = 32;         // rgba word
  localparam int CFG_W   = 9;          // width of the side field taken from a register write
  localparam int PADDR_W = 4;          // three registers at 4-byte spacing
  localparam int PDATA_W = 32;

  // register indexes (paddr word index)
  localparam logic [1:0] REG_SRC_WIDTH   = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_EXPAND_MODE = 2'd2;

  // input word command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic store;    // write the incoming pixel into the source store
    logic capture;  // latch fetch coordinates
    logic calc;     // compute and register the source address and flags
    logic read;     // read the source store
    logic load;     // move the fetched word into the output register
  } p2tr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free; // output register can take a word this cycle
  } p2tr_sts_t;

endpackage

// ===== hw/rtl/p2tr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2tr_ctrl
// sequencer for one input word at a time: stores finish on acceptance,
// fetches walk through address calc, store read and output load
// ----------------------------------------------------------------------------
module p2tr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  p2tr_pkg::p2tr_sts_t  sts_i,
  output p2tr_pkg::p2tr_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i == p2tr_pkg::CMD_STORE) begin
            cmd_o.store = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
            state_d       = S_CALC;
          end
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/p2tr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2tr_datapath
// source store, nearest-neighbor address calc and the output register
// ----------------------------------------------------------------------------
module p2tr_datapath #(
  parameter int MAX_SIDE = p2tr_pkg::MAX_SIDE_DEF,
  localparam int SIDE_W  = $clog2(MAX_SIDE + 1),
  localparam int LOG_MAX = $clog2(MAX_SIDE),
  localparam int LOGW_W  = $clog2(LOG_MAX + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input word
  input  logic [p2tr_pkg::COL_W-1:0] col_i,
  input  logic [p2tr_pkg::COL_W-1:0] row_i,
  input  logic [p2tr_pkg::PIX_W-1:0] pixel_in_i,
  // configuration
  input  logic [SIDE_W-1:0]          src_w_i,
  input  logic [SIDE_W-1:0]          src_h_i,
  input  logic [LOGW_W-1:0]          log_w_i,
  input  logic [LOGW_W-1:0]          log_h_i,
  input  logic                       expand_i,
  // result word
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [p2tr_pkg::PIX_W-1:0] pixel_out_o,
  output logic                       out_of_range_o,
  // control
  input  p2tr_pkg::p2tr_cmd_t        cmd_i,
  output p2tr_pkg::p2tr_sts_t        sts_o
);

  localparam int COORD_W = (LOG_MAX > 0) ? LOG_MAX : 1;
  localparam int ADDR_W  = 2 * COORD_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int PROD_W  = p2tr_pkg::COL_W + SIDE_W;
  localparam int CMP_W   = (SIDE_W > p2tr_pkg::COL_W) ? SIDE_W : p2tr_pkg::COL_W;

  logic [p2tr_pkg::PIX_W-1:0] mem [DEPTH];

  // store side
  logic [CMP_W-1:0]  wcol_ext, wrow_ext;
  logic              wr_in_store;
  logic [ADDR_W-1:0] waddr;

  assign wcol_ext    = CMP_W'(col_i);
  assign wrow_ext    = CMP_W'(row_i);
  assign wr_in_store = (wcol_ext < CMP_W'(MAX_SIDE)) && (wrow_ext < CMP_W'(MAX_SIDE));
  assign waddr       = {wrow_ext[COORD_W-1:0], wcol_ext[COORD_W-1:0]};

  // fetch side
  logic [p2tr_pkg::COL_W-1:0] col_q, row_q;
  logic [p2tr_pkg::COL_W-1:0] col_hi, row_hi;
  logic [PROD_W-1:0]          prod_x, prod_y, fx_full, fy_full;
  logic [CMP_W-1:0]           col_ext, row_ext;
  logic                       outside_dst, inside_src;
  logic [ADDR_W-1:0]          raddr_d;

  logic [ADDR_W-1:0]          raddr_q;
  logic                       oor_q, zero_q;
  logic [p2tr_pkg::PIX_W-1:0] rdata_q;

  logic                       out_valid_q;
  logic [p2tr_pkg::PIX_W-1:0] pixel_q;
  logic                       flag_q;

  always_comb begin
    col_hi      = col_q >> log_w_i;
    row_hi      = row_q >> log_h_i;
    outside_dst = (|col_hi) || (|row_hi);

    col_ext    = CMP_W'(col_q);
    row_ext    = CMP_W'(row_q);
    inside_src = (col_ext < CMP_W'(src_w_i)) && (row_ext < CMP_W'(src_h_i));

    // scaled coordinate stays below the source side
    prod_x  = PROD_W'(col_q) * PROD_W'(src_w_i);
    prod_y  = PROD_W'(row_q) * PROD_W'(src_h_i);
    fx_full = prod_x >> log_w_i;
    fy_full = prod_y >> log_h_i;

    if (expand_i) begin
      raddr_d = {fy_full[COORD_W-1:0], fx_full[COORD_W-1:0]};
    end else begin
      raddr_d = {row_ext[COORD_W-1:0], col_ext[COORD_W-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      col_q <= col_i;
      row_q <= row_i;
    end
    if (cmd_i.calc) begin
      raddr_q <= raddr_d;
      oor_q   <= outside_dst;
      zero_q  <= outside_dst || (!expand_i && !inside_src);
    end
  end

  // single-port source store
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && wr_in_store) begin
      mem[waddr] <= pixel_in_i;
    end
    if (cmd_i.read) begin
      rdata_q <= mem[raddr_q];
    end
  end

  // output register
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pixel_q <= zero_q ? '0 : rdata_q;
      flag_q  <= oor_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_out_o    = pixel_q;
  assign out_of_range_o = flag_q;

endmodule

// ===== hw/rtl/pow2_texture_resample_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pow2_texture_resample_core
// nearest-neighbor resampling of a stored rgba image onto a power-of-two
// texture, with an apb-style register port
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) carries a word of cmd, col, row
//   and pixel_in. a store word writes pixel_in at (col, row) of the source
//   store and gives no result. a fetch word asks for destination pixel
//   (col, row) and gives one result word on the output channel
//   (out_valid_o / out_stall_i) with pixel_out and out_of_range.
//   sequence: a store is written on acceptance. a fetch holds off the input
//   while it runs address calc with the scaling multiply, one read of the
//   single store port and output load; its result is registered by the load.
//   one word is in flight at a time; a finished result waits in the output
//   register, and if the receiver stalls a following fetch waits in its load
//   step until that register frees up, holding off the input. stores are
//   still taken while a result waits and no fetch is in its load step.
//   reset clears the sequencer and output valid and sets src_width = 1,
//   src_height = 1, expand_mode = 1. the source store is not cleared;
//   configure only while the block is idle.
// ----------------------------------------------------------------------------
module pow2_texture_resample_core #(
  parameter int MAX_SIDE = p2tr_pkg::MAX_SIDE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [p2tr_pkg::COL_W-1:0]   col_i,
  input  logic [p2tr_pkg::COL_W-1:0]   row_i,
  input  logic [p2tr_pkg::PIX_W-1:0]   pixel_in_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [p2tr_pkg::PIX_W-1:0]   pixel_out_o,
  output logic                         out_of_range_o,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [p2tr_pkg::PADDR_W-1:0] paddr,
  input  logic [p2tr_pkg::PDATA_W-1:0] pwdata,
  output logic [p2tr_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int LOG_MAX = $clog2(MAX_SIDE);
  localparam int LOGW_W  = $clog2(LOG_MAX + 1);
  localparam int CMP_W   = (SIDE_W > p2tr_pkg::CFG_W) ? SIDE_W : p2tr_pkg::CFG_W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // side registers hold the clamped value; the texture side log2 is
  // worked out once at write time so the fetch path only shifts
  // ---------------------------------------------------------------------------
  logic [SIDE_W-1:0] src_w_q, src_h_q;
  logic [LOGW_W-1:0] log_w_q, log_h_q;
  logic              expand_q;

  logic              reg_wr;
  logic [1:0]        reg_idx;
  logic [CMP_W-1:0]  wr_ext;
  logic [SIDE_W-1:0] wr_side, side_m1;
  logic [LOGW_W-1:0] wr_log;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // saturate to 1..MAX_SIDE, then log2 of the next power of two is the
  // bit length of side-1
  always_comb begin
    wr_ext = CMP_W'(pwdata[p2tr_pkg::CFG_W-1:0]);
    if (wr_ext == '0) begin
      wr_side = SIDE_W'(1);
    end else if (wr_ext > CMP_W'(MAX_SIDE)) begin
      wr_side = SIDE_W'(MAX_SIDE);
    end else begin
      wr_side = SIDE_W'(wr_ext);
    end
    side_m1 = wr_side - SIDE_W'(1);
    wr_log  = '0;
    for (int b = 0; b < SIDE_W; b++) begin
      if (side_m1[b]) wr_log = LOGW_W'(b + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= SIDE_W'(1);
      src_h_q  <= SIDE_W'(1);
      log_w_q  <= '0;
      log_h_q  <= '0;
      expand_q <= 1'b1;
    end else if (reg_wr) begin
      unique case (reg_idx)
        p2tr_pkg::REG_SRC_WIDTH: begin
          src_w_q <= wr_side;
          log_w_q <= wr_log;
        end
        p2tr_pkg::REG_SRC_HEIGHT: begin
          src_h_q <= wr_side;
          log_h_q <= wr_log;
        end
        p2tr_pkg::REG_EXPAND_MODE: begin
          expand_q <= pwdata[0];
        end
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      p2tr_pkg::REG_SRC_WIDTH:   prdata = p2tr_pkg::PDATA_W'(src_w_q);
      p2tr_pkg::REG_SRC_HEIGHT:  prdata = p2tr_pkg::PDATA_W'(src_h_q);
      p2tr_pkg::REG_EXPAND_MODE: prdata = p2tr_pkg::PDATA_W'(expand_q);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer and datapath
  // ---------------------------------------------------------------------------
  p2tr_pkg::p2tr_cmd_t ctl_cmd;
  p2tr_pkg::p2tr_sts_t dp_sts;

  p2tr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .sts_i      (dp_sts),
    .cmd_o      (ctl_cmd)
  );

  p2tr_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .col_i          (col_i),
    .row_i          (row_i),
    .pixel_in_i     (pixel_in_i),
    .src_w_i        (src_w_q),
    .src_h_i        (src_h_q),
    .log_w_i        (log_w_q),
    .log_h_i        (log_h_q),
    .expand_i       (expand_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_out_o    (pixel_out_o),
    .out_of_range_o (out_of_range_o),
    .cmd_i          (ctl_cmd),
    .sts_o          (dp_sts)
  );

endmodule

// ===== verif/p2tr_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2tr_tb_pkg
// texel predictor and result checker for the power-of-two resample core
// ----------------------------------------------------------------------------
package p2tr_tb_pkg;

  import p2tr_pkg::*;

  localparam int SIDE        = MAX_SIDE_DEF;
  localparam int NO_TEXEL    = -1;  // pad mode, outside the source area
  localparam int OFF_TEXTURE = -2;  // fetch beyond the destination texture

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             off_texture;
  } texel_t;

  class texel_predictor;
    bit [PIX_W-1:0] src_image [SIDE*SIDE];
    int unsigned    src_w   = 1;
    int unsigned    src_h   = 1;
    bit             stretch = 1'b1;
    texel_t         texels_due [$];
    int             errors  = 0;

    // side registers saturate into 1..SIDE
    function void set_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
      int unsigned side;
      side = value[CFG_W-1:0];
      if (side == 0) side = 1;
      else if (side > SIDE) side = SIDE;
      if (idx == REG_SRC_WIDTH) src_w = side;
      else if (idx == REG_SRC_HEIGHT) src_h = side;
      else if (idx == REG_EXPAND_MODE) stretch = value[0];
    endfunction

    function int unsigned pot_bits(int unsigned n);
      int unsigned k = 0;
      while ((1 << k) < n) k++;
      return k;
    endfunction

    function int unsigned dst_w();
      return 1 << pot_bits(src_w);
    endfunction

    function int unsigned dst_h();
      return 1 << pot_bits(src_h);
    endfunction

    // source store entry a fetch reads, or a code when it reads none
    function int texel_index(int unsigned col, int unsigned row);
      int unsigned lw;
      int unsigned lh;
      lw = pot_bits(src_w);
      lh = pot_bits(src_h);
      if (col >= (1 << lw) || row >= (1 << lh)) return OFF_TEXTURE;
      if (stretch) return ((row * src_h) >> lh) * SIDE + ((col * src_w) >> lw);
      if (col < src_w && row < src_h) return row * SIDE + col;
      return NO_TEXEL;
    endfunction

    function void take_word(logic cmd, logic [COL_W-1:0] col, logic [COL_W-1:0] row,
                            logic [PIX_W-1:0] pix);
      texel_t t;
      int     idx;
      if (cmd == CMD_STORE) begin
        src_image[row * SIDE + col] = pix;
      end else begin
        idx           = texel_index(col, row);
        t.off_texture = (idx == OFF_TEXTURE);
        t.pixel       = (idx >= 0) ? src_image[idx] : '0;
        texels_due.push_back(t);
      end
    endfunction

    function void check_texel(logic [PIX_W-1:0] pix, logic off_texture);
      texel_t t;
      if (texels_due.size() == 0) begin
        $error("result word with no fetch outstanding: pixel_out %h", pix);
        errors++;
      end else begin
        t = texels_due.pop_front();
        if (pix !== t.pixel) begin
          $error("pixel_out: expected %h, got %h", t.pixel, pix);
          errors++;
        end
        if (off_texture !== t.off_texture) begin
          $error("out_of_range: expected %b, got %b", t.off_texture, off_texture);
          errors++;
        end
      end
    endfunction

    function int pending();
      return texels_due.size();
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives store and fetch words through the resample core under a series of
// source sizes and both modes, and checks each fetched texel against a
// predictor that follows every accepted word
// ----------------------------------------------------------------------------
module tb_top;

  import p2tr_pkg::*;
  import p2tr_tb_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int HOLD_CYCLES = 300;   // one long receiver hold-off
  localparam int HOLD_AFTER  = 120;   // results seen before the hold-off starts
  localparam int SETTLE      = 8;     // extra wait after the last expected result

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic                 cmd_i          = CMD_STORE;
  logic [COL_W-1:0]     col_i          = '0;
  logic [COL_W-1:0]     row_i          = '0;
  logic [PIX_W-1:0]     pixel_in_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [PIX_W-1:0]     pixel_out_o;
  logic                 out_of_range_o;
  logic                 psel           = 1'b0;
  logic                 penable        = 1'b0;
  logic                 pwrite         = 1'b0;
  logic [PADDR_W-1:0]   paddr          = '0;
  logic [PDATA_W-1:0]   pwdata         = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  texel_predictor sb;

  // source entries the stimulus has written so far; a fetch never lands on
  // an entry outside this set
  bit filled [SIDE*SIDE];

  bit calm        = 1'b0;  // no idling on either side while set
  int results_seen = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  pow2_texture_resample_core dut (.*);

  // ---------------------------------------------------------------------------
  // monitor: every accepted input word goes to the predictor, every accepted
  // result word is checked against the oldest expected texel
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.take_word(cmd_i, col_i, row_i, pixel_in_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_texel(pixel_out_o, out_of_range_o);
        results_seen <= results_seen + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off so the core fills up and
  // pushes back on the input while the sender keeps offering words
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 8);
    end
  end

  // watchdog: ends the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // present one word, now and then with a random gap ahead of it, and hold it until taken
  task automatic send_word(logic cmd, logic [COL_W-1:0] col, logic [COL_W-1:0] row,
                           logic [PIX_W-1:0] pix);
    if (!calm && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    col_i      <= col;
    row_i      <= row;
    pixel_in_i <= pix;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic store(logic [COL_W-1:0] col, logic [COL_W-1:0] row, logic [PIX_W-1:0] pix);
    filled[row * SIDE + col] = 1'b1;
    send_word(CMD_STORE, col, row, pix);
  endtask

  // a fetch whose source entry was never written gets a store to it first
  task automatic fetch(logic [COL_W-1:0] col, logic [COL_W-1:0] row);
    int idx;
    idx = sb.texel_index(col, row);
    if (idx >= 0 && !filled[idx]) store(COL_W'(idx % SIDE), COL_W'(idx / SIDE), $urandom());
    send_word(CMD_FETCH, col, row, $urandom());
  endtask

  // stop offering words and wait until every expected texel has come back;
  // the extra edge lets the monitor note the last accepted word first
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // setup phase, access phase, then an idle phase on the bus
  task automatic reg_write(logic [1:0] idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(int unsigned w, int unsigned h, bit mode);
    drain();
    reg_write(REG_SRC_WIDTH, w);
    reg_write(REG_SRC_HEIGHT, h);
    reg_write(REG_EXPAND_MODE, PDATA_W'(mode));
  endtask

  // mostly stores into the source area and fetches inside the texture,
  // with some stores anywhere and fetches anywhere in the coordinate range
  task automatic run_phase(int unsigned w, int unsigned h, bit mode, int unsigned words);
    int unsigned pick;
    configure(w, h, mode);
    repeat (words) begin
      pick = $urandom_range(99);
      if (pick < 35) store(COL_W'($urandom_range(sb.src_w - 1)),
                           COL_W'($urandom_range(sb.src_h - 1)), $urandom());
      else if (pick < 45) store(COL_W'($urandom_range(255)), COL_W'($urandom_range(255)),
                                $urandom());
      else if (pick < 90) fetch(COL_W'($urandom_range(sb.dst_w() - 1)),
                                COL_W'($urandom_range(sb.dst_h() - 1)));
      else fetch(COL_W'($urandom_range(255)), COL_W'($urandom_range(255)));
    end
  endtask

  // mostly small sides, now and then a large one
  function automatic int unsigned pick_side();
    return ($urandom_range(7) == 0) ? $urandom_range(17, 256) : $urandom_range(1, 16);
  endfunction

  task automatic directed();
    // reset sizes: 1x1 source on a 1x1 texture, expand mode
    store(0, 0, 32'hFFFF_FFFF);
    fetch(0, 0);
    fetch(1, 0);          // just past the texture edge
    fetch(0, 1);
    fetch(255, 255);      // far corner
    store(255, 255, 32'h0000_0000);  // lands outside the source area
    fetch(0, 0);
    // 5x3 source padded onto an 8x4 texture
    configure(5, 3, 1'b0);
    store(4, 2, 32'hA5A5_A5A5);
    store(0, 0, 32'h0000_0000);
    fetch(4, 2);          // last source pixel
    fetch(0, 0);
    fetch(6, 1);          // pad region, zero but in range
    fetch(7, 3);
    fetch(8, 0);          // off the texture
    fetch(0, 4);
    // same source stretched
    configure(5, 3, 1'b1);
    store(2, 1, 32'h5A5A_5A5A);
    fetch(7, 3);          // last texel maps onto the last source pixel
    fetch(3, 2);
    fetch(4, 2);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();

    // extremes of the side registers, both modes, saturation of 0 and oversize
    run_phase(256, 256, 1'b1, 32);
    run_phase(256, 256, 1'b0, 32);
    run_phase(0, 0, 1'b1, 32);
    run_phase(511, 300, 1'b0, 32);
    calm <= 1'b1;
    run_phase(2, 2, 1'b1, 32);
    calm <= 1'b0;
    run_phase(129, 200, 1'b1, 32);
    run_phase(100, 37, 1'b0, 32);
    run_phase(1, 256, 1'b1, 32);
    run_phase(256, 1, 1'b0, 32);

    repeat (8) run_phase(pick_side(), pick_side(), 1'($urandom_range(1)), 40);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
